// File: sv/edf_pkg.sv
// edf scheduler package: widths, mode codes, cell and scan types
// no dependencies
package edf_pkg;
  localparam int TaskCount = 32;
  localparam int TimeWidth = 16;
  localparam int SlotWidth = 6;
  localparam int FieldWidth = 16;

  typedef logic [TimeWidth-1:0] time_t;
  typedef logic [SlotWidth-1:0] slot_t;
  typedef logic [TaskCount-1:0] mask_t;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_DELAY = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  // command broadcast to every cell for one cycle
  typedef struct packed {
    logic  tick;
    logic  load;
    logic  delay;
    slot_t slot;
    time_t cost;
    time_t deadline;
    time_t period;
    time_t wait_ticks;
    slot_t running;
  } cmd_t;

  // best candidate passed down the chain
  typedef struct packed {
    logic  found;
    slot_t idx;
    time_t dl;
  } cand_t;

  // status of one cell
  typedef struct packed {
    logic ready;
    logic waiting;
  } cell_stat_t;
endpackage

// File: sv/edf_if.sv
// valid/ready channel interfaces for the edf scheduler
// no dependencies
interface edf_in_if (input logic clk);
  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic [5:0]               task_slot;
  logic [15:0]              cost_reload;
  logic [15:0]              deadline_reload;
  logic [15:0]              period_reload;
  logic [15:0]              delay_ticks;
  modport source (output valid, mode, task_slot, cost_reload, deadline_reload,
                  period_reload, delay_ticks, input ready);
  modport sink (input valid, mode, task_slot, cost_reload, deadline_reload,
                period_reload, delay_ticks, output ready);
endinterface

interface edf_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [5:0]  selected_task;
  logic        switch_needed;
  logic [31:0] ready_mask;
  logic [31:0] delayed_mask;
  modport source (output valid, selected_task, switch_needed, ready_mask,
                  delayed_mask, input ready);
  modport sink (input valid, selected_task, switch_needed, ready_mask,
                delayed_mask, output ready);
endinterface

// File: sv/edf_cell.sv
// one task slot: live counters, reload values, delay timer, chain compare
// depends on edf_pkg
module edf_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  edf_pkg::slot_t     my_idx,
  input  edf_pkg::cmd_t      cmd,
  input  logic               cmd_en,
  input  logic               scan_en,
  input  edf_pkg::cand_t     cand_in,
  output edf_pkg::cand_t     cand_out,
  output edf_pkg::cell_stat_t stat
);
  import edf_pkg::*;

  time_t cost_r, dl_r, per_r, wait_r;
  time_t cost_full_r, dl_full_r, per_full_r;
  logic  rdy_r, wt_r;
  cand_t cand_r;
  time_t cost_nxt, dl_nxt, per_nxt, wait_nxt;
  logic  rdy_nxt, wt_nxt;
  logic  rdy_t, wt_t;
  logic  hit, take;

  assign hit = (cmd.slot == my_idx);

  always_comb begin
    cost_nxt = cost_r;
    dl_nxt   = dl_r;
    per_nxt  = per_r;
    wait_nxt = wait_r;
    rdy_nxt  = rdy_r;
    wt_nxt   = wt_r;
    rdy_t    = rdy_r;
    wt_t     = wt_r;
    if (cmd_en && cmd.tick) begin
      if (wt_r) begin
        if (wait_r <= time_t'(1)) begin
          wait_nxt = '0;
          wt_t     = 1'b0;
          rdy_t    = 1'b1;
        end else begin
          wait_nxt = wait_r - time_t'(1);
        end
      end
      rdy_nxt = rdy_t;
      wt_nxt  = wt_t;
      if (rdy_t || wt_t) begin
        if (cmd.running == my_idx && cost_r != '0) cost_nxt = cost_r - time_t'(1);
        dl_nxt  = dl_r - time_t'(1);
        per_nxt = per_r - time_t'(1);
        if (per_nxt == '0) begin
          cost_nxt = cost_full_r;
          dl_nxt   = dl_full_r;
          per_nxt  = per_full_r;
        end
      end
    end else if (cmd_en && cmd.load && hit) begin
      cost_nxt = cmd.cost;
      dl_nxt   = cmd.deadline;
      per_nxt  = cmd.period;
      wait_nxt = '0;
      wt_nxt   = 1'b0;
      rdy_nxt  = 1'b1;
    end else if (cmd_en && cmd.delay && cmd.running == my_idx) begin
      wait_nxt = cmd.wait_ticks;
      rdy_nxt  = 1'b0;
      wt_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r <= '0;
      dl_r   <= '0;
      per_r  <= '0;
      wait_r <= '0;
      rdy_r  <= 1'b0;
      wt_r   <= 1'b0;
    end else begin
      cost_r <= cost_nxt;
      dl_r   <= dl_nxt;
      per_r  <= per_nxt;
      wait_r <= wait_nxt;
      rdy_r  <= rdy_nxt;
      wt_r   <= wt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_en && cmd.load && hit) begin
      cost_full_r <= cmd.cost;
      dl_full_r   <= cmd.deadline;
      per_full_r  <= cmd.period;
    end
  end

  // chain runs from highest slot downwards
  always_comb begin
    take = 1'b0;
    if ((rdy_r || wt_r) && cost_r != '0) begin
      take = !cand_in.found || (dl_r < cand_in.dl) ||
             (dl_r == cand_in.dl && cmd.running == my_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (scan_en) begin
      cand_r <= take ? cand_t'{found: 1'b1, idx: my_idx, dl: dl_r} : cand_in;
    end
  end

  assign cand_out = cand_r;
  assign stat     = '{ready: rdy_r, waiting: wt_r};
endmodule

// File: sv/edf_periodic_task_scheduler.sv
// Each item passes through the command, scan and output states: the command
// state applies the command to all slot cells, the scan state lets the
// candidate walk the chain of cells one slot per cycle, highest slot first,
// and the output state registers the result. A new item is taken only back
// in idle, once the last result is registered; a result still waiting in the
// output register holds the next one back until it has left.
// depends on edf_pkg, edf_if, edf_cell
module edf_periodic_task_scheduler (
  input logic clk,
  input logic rst_n,
  edf_in_if.sink    in_ch,
  edf_out_if.source out_ch
);
  import edf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMD  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  cmd_t   cmd_r;
  slot_t  run_r, prev_r;
  logic [SlotWidth:0] cnt_r;
  cand_t  chain [TaskCount+1];
  cell_stat_t stat [TaskCount];
  mask_t  rmask, dmask;
  logic   ovalid_r;
  logic   scan_en;
  slot_t  sel;
  cmd_t   cmd_in;
  time_t  wt_in;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign scan_en = (state_r == ST_SCAN);
  assign chain[TaskCount] = '{found: 1'b0, idx: '0, dl: '0};

  always_comb begin
    wt_in = in_ch.delay_ticks[TimeWidth-1:0];
    if (wt_in == '0) wt_in = time_t'(1);
    cmd_in.tick       = (mode_t'(in_ch.mode) == MODE_TICK);
    cmd_in.load       = (mode_t'(in_ch.mode) == MODE_LOAD);
    cmd_in.delay      = (mode_t'(in_ch.mode) == MODE_DELAY) && (run_r != '0);
    cmd_in.slot       = in_ch.task_slot;
    cmd_in.cost       = in_ch.cost_reload[TimeWidth-1:0];
    cmd_in.deadline   = in_ch.deadline_reload[TimeWidth-1:0];
    cmd_in.period     = in_ch.period_reload[TimeWidth-1:0];
    cmd_in.wait_ticks = wt_in;
    cmd_in.running    = run_r;
  end

  genvar g;
  for (g = 0; g < TaskCount; g++) begin : g_cell
    edf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .my_idx   (slot_t'(g + 1)),
      .cmd      (cmd_r),
      .cmd_en   (state_r == ST_CMD),
      .scan_en  (scan_en),
      .cand_in  (chain[g+1]),
      .cand_out (chain[g]),
      .stat     (stat[g])
    );
    assign rmask[g] = stat[g].ready;
    assign dmask[g] = stat[g].waiting;
  end

  assign sel = chain[0].found ? chain[0].idx : '0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_CMD;
      ST_CMD:  state_nxt = ST_SCAN;
      ST_SCAN: if (cnt_r == (SlotWidth+1)'(TaskCount)) state_nxt = ST_OUT;
      ST_OUT:  if (!ovalid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      run_r    <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CMD) cnt_r <= '0;
      else if (scan_en) cnt_r <= cnt_r + 1'b1;
      if (state_r == ST_OUT && state_nxt == ST_IDLE) begin
        ovalid_r <= 1'b1;
        run_r    <= sel;
      end else if (out_ch.valid && out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r  <= cmd_in;
      prev_r <= run_r;
    end
    if (state_r == ST_OUT && state_nxt == ST_IDLE) begin
      out_ch.selected_task <= sel;
      out_ch.switch_needed <= (sel != prev_r);
      out_ch.ready_mask    <= rmask;
      out_ch.delayed_mask  <= dmask;
    end
  end

  assign out_ch.valid = ovalid_r;
endmodule

// File: sv/edf_checker.sv
// port-level checks for the edf scheduler
// depends on edf_if; bound to edf_periodic_task_scheduler
module edf_checker (
  input logic clk,
  input logic rst_n,
  edf_in_if.sink    in_ch,
  edf_out_if.source out_ch
);
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.selected_task))
    else $error("result changed while stalled");
  a_one_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.ready_mask & out_ch.delayed_mask) == 32'd0)
    else $error("task both ready and delayed");
  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.selected_task <= 6'd32)
    else $error("selected task out of range");
  a_no_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item taken in consecutive cycles");
endmodule

bind edf_periodic_task_scheduler edf_checker u_edf_checker (
  .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
);

// File: tb/sv/edf_sched_checker.sv
// checker for the edf scheduler: watches both channels, predicts each result
// from its own model of the task table and compares field by field
// depends on edf_pkg, edf_if
`timescale 1ns / 1ps
module edf_sched_checker (
  input  logic       clk,
  input  logic       rst_n,
  edf_in_if          in_ch,
  edf_out_if         out_ch,
  output int         fail_count,
  output int         pending
);
  import edf_pkg::*;

  typedef struct packed {
    slot_t sel;
    logic  sw;
    mask_t rdy;
    mask_t dly;
  } sched_res_t;

  time_t      cost_now [1:TaskCount];
  time_t      dl_now [1:TaskCount];
  time_t      per_now [1:TaskCount];
  time_t      cost_rl [1:TaskCount];
  time_t      dl_rl [1:TaskCount];
  time_t      per_rl [1:TaskCount];
  time_t      wait_now [1:TaskCount];
  mask_t      rdy_set;
  mask_t      dly_set;
  slot_t      running;
  sched_res_t expected_q[$];

  task automatic advance_tick();
    mask_t reg_set;
    for (int i = 1; i <= TaskCount; i++) begin
      if (dly_set[i-1]) begin
        if (wait_now[i] <= 1) begin
          wait_now[i] = '0;
          dly_set[i-1] = 1'b0;
          rdy_set[i-1] = 1'b1;
        end else begin
          wait_now[i] = wait_now[i] - 1'b1;
        end
      end
    end
    reg_set = rdy_set | dly_set;
    for (int i = 1; i <= TaskCount; i++) begin
      if (reg_set[i-1]) begin
        if (i == running && cost_now[i] != 0) cost_now[i] = cost_now[i] - 1'b1;
        dl_now[i] = dl_now[i] - 1'b1;
        per_now[i] = per_now[i] - 1'b1;
        if (per_now[i] == 0) begin
          cost_now[i] = cost_rl[i];
          dl_now[i] = dl_rl[i];
          per_now[i] = per_rl[i];
        end
      end
    end
  endtask

  function automatic slot_t pick_earliest();
    slot_t best;
    time_t best_dl;
    mask_t reg_set;
    best = '0;
    best_dl = '0;
    reg_set = rdy_set | dly_set;
    for (int i = TaskCount; i >= 1; i--) begin
      if (reg_set[i-1] && cost_now[i] != 0) begin
        if (best == 0 || dl_now[i] < best_dl || (dl_now[i] == best_dl && i == running)) begin
          best = slot_t'(i);
          best_dl = dl_now[i];
        end
      end
    end
    return best;
  endfunction

  task automatic schedule_item(mode_t md, slot_t sl, time_t c, time_t d, time_t p, time_t w);
    slot_t      prev;
    sched_res_t r;
    prev = running;
    case (md)
      MODE_TICK: advance_tick();
      MODE_LOAD: begin
        if (sl >= 1 && sl <= TaskCount) begin
          cost_rl[sl] = c;
          dl_rl[sl] = d;
          per_rl[sl] = p;
          cost_now[sl] = c;
          dl_now[sl] = d;
          per_now[sl] = p;
          wait_now[sl] = '0;
          dly_set[sl-1] = 1'b0;
          rdy_set[sl-1] = 1'b1;
        end
      end
      MODE_DELAY: begin
        if (running >= 1 && running <= TaskCount) begin
          wait_now[running] = (w == 0) ? time_t'(1) : w;
          rdy_set[running-1] = 1'b0;
          dly_set[running-1] = 1'b1;
        end
      end
      default: ;
    endcase
    running = pick_earliest();
    r.sel = running;
    r.sw = (running != prev);
    r.rdy = rdy_set;
    r.dly = dly_set;
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    sched_res_t e;
    if (!rst_n) begin
      for (int i = 1; i <= TaskCount; i++) begin
        cost_now[i] = '0;
        dl_now[i] = '0;
        per_now[i] = '0;
        cost_rl[i] = '0;
        dl_rl[i] = '0;
        per_rl[i] = '0;
        wait_now[i] = '0;
      end
      rdy_set = '0;
      dly_set = '0;
      running = '0;
      fail_count = 0;
      pending = expected_q.size();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result: task %0d", out_ch.selected_task);
        end else begin
          e = expected_q.pop_front();
          if (out_ch.selected_task !== e.sel || out_ch.switch_needed !== e.sw ||
              out_ch.ready_mask !== e.rdy || out_ch.delayed_mask !== e.dly) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp task %0d sw %0b rdy %h dly %h, got %0d %0b %h %h",
                       e.sel, e.sw, e.rdy, e.dly, out_ch.selected_task,
                       out_ch.switch_needed, out_ch.ready_mask, out_ch.delayed_mask);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        schedule_item(mode_t'(in_ch.mode), in_ch.task_slot, in_ch.cost_reload,
                      in_ch.deadline_reload, in_ch.period_reload, in_ch.delay_ticks);
      pending = expected_q.size();
    end
  end
endmodule

// File: tb/sv/tb.sv
// top of the edf scheduler testbench: clock, reset, stimulus and verdict
// depends on edf_pkg, edf_if, edf_sched_checker and the scheduler rtl
`timescale 1ns / 1ps
module tb;
  import edf_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   send_idle;
  int   recv_stall;

  edf_in_if  in_ch (clk);
  edf_out_if out_ch (clk);

  edf_periodic_task_scheduler u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  edf_sched_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= recv_stall);

  task automatic send_item(mode_t md, int sl, int c, int d, int p, int w);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= md;
    in_ch.task_slot <= sl[5:0];
    in_ch.cost_reload <= c[15:0];
    in_ch.deadline_reload <= d[15:0];
    in_ch.period_reload <= p[15:0];
    in_ch.delay_ticks <= w[15:0];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 55) send_item(MODE_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
    else if (r < 75)
      send_item(MODE_LOAD, $urandom_range(1, 32), $urandom_range(0, 6),
                $urandom_range(0, 40), $urandom_range(0, 30), $urandom);
    else if (r < 92)
      send_item(MODE_DELAY, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 8));
    else if (r < 95)
      send_item(MODE_LOAD, $urandom_range(0, 63), $urandom, $urandom, $urandom, $urandom);
    else if (r < 97)
      send_item(MODE_DELAY, $urandom, $urandom, $urandom, $urandom, $urandom);
    else send_item(MODE_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    rst_n = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_TICK;
    in_ch.task_slot = '0;
    in_ch.cost_reload = '0;
    in_ch.deadline_reload = '0;
    in_ch.period_reload = '0;
    in_ch.delay_ticks = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: idle delay, extremes, ties, wrap, zero period, bad slots
    send_item(MODE_DELAY, 0, 0, 0, 0, 5);
    send_item(MODE_TICK, 0, 0, 0, 0, 0);
    send_item(MODE_LOAD, 0, 5, 5, 5, 0);
    send_item(MODE_LOAD, 33, 5, 5, 5, 0);
    send_item(MODE_LOAD, 63, 5, 5, 5, 0);
    send_item(MODE_LOAD, 32, 65535, 65535, 65535, 0);
    send_item(MODE_LOAD, 1, 3, 10, 1, 0);
    send_item(MODE_LOAD, 2, 3, 10, 0, 0);
    send_item(MODE_LOAD, 3, 0, 0, 4, 0);
    send_item(MODE_TICK, 0, 0, 0, 0, 0);
    send_item(MODE_LOAD, 5, 2, 9, 8, 0);
    send_item(MODE_LOAD, 6, 2, 9, 8, 0);
    send_item(MODE_TICK, 0, 0, 0, 0, 0);
    send_item(MODE_DELAY, 0, 0, 0, 0, 0);
    send_item(MODE_DELAY, 0, 0, 0, 0, 65535);
    send_item(MODE_TICK, 0, 0, 0, 0, 0);
    send_item(MODE_LOAD, 16, 21845, 43690, 1, 0);
    send_item(MODE_NOP, 63, 65535, 65535, 65535, 65535);
    send_item(MODE_DELAY, 0, 0, 0, 0, 2);
    send_item(MODE_TICK, 0, 0, 0, 0, 0);
    send_item(MODE_TICK, 0, 0, 0, 0, 0);
    send_item(MODE_LOAD, 6, 1, 0, 65535, 0);
    send_item(MODE_TICK, 0, 0, 0, 0, 0);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 51 : 17) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 51 : 17) : 0;
      for (int n = 0; n < 450; n++) random_item();
    end
    in_ch.valid <= 1'b0;
    recv_stall = 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

// File: edf_periodic_task_scheduler.f
sv/edf_pkg.sv
sv/edf_if.sv
sv/edf_cell.sv
sv/edf_periodic_task_scheduler.sv
sv/edf_checker.sv
tb/sv/edf_sched_checker.sv
tb/sv/tb.sv
